FILE: rtl/core/eigen_pair_rank_by_target_top_defines.svh
// Assertion macros for the eigen pair ranking block.
`ifndef EIGEN_PAIR_RANK_BY_TARGET_TOP_DEFINES_SVH
`define EIGEN_PAIR_RANK_BY_TARGET_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define EPRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EPRT_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPRT_ASSERT(lbl, clk, rst, prop, msg)
`define EPRT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/eprt_pkg.sv
package eprt_pkg;

   localparam int MAX_PAIRS_DEF = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int KEY_W         = 48;
   localparam logic [KEY_W-1:0] KEY_MAX     = 48'h7FFF_FFFF_FFFF;
   localparam logic [KEY_W-1:0] KEY_MAX_NEG = 48'h8000_0000_0001;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_RE    = 3'd0,
      CSR_A_IM    = 3'd1,
      CSR_B_RE    = 3'd2,
      CSR_B_IM    = 3'd3,
      CSR_CHORDAL = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_ZERO = 4'd0,
      OP_SR   = 4'd1,
      OP_SI   = 4'd2,
      OP_TR   = 4'd3,
      OP_TI   = 4'd4,
      OP_AR   = 4'd5,
      OP_AI   = 4'd6,
      OP_BR   = 4'd7,
      OP_BI   = 4'd8,
      OP_T0L  = 4'd9,
      OP_T0H  = 4'd10,
      OP_T1L  = 4'd11,
      OP_T1H  = 4'd12
   } opnd_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_T0   = 3'd1,
      DST_T1   = 3'd2,
      DST_NUM  = 3'd3,
      DST_DEN  = 3'd4
   } dst_type;

   typedef struct packed {
      opnd_type   a;
      opnd_type   b;
      logic [1:0] sh32;
      logic       neg;
      dst_type    dst;
      logic       last;
   } uop_type;

   function automatic uop_type mk(opnd_type a, opnd_type b, logic [1:0] sh32,
                                  logic neg, dst_type dst, logic last);
      uop_type u;
      u.a    = a;
      u.b    = b;
      u.sh32 = sh32;
      u.neg  = neg;
      u.dst  = dst;
      u.last = last;
      return u;
   endfunction

   // squares of the two 64-bit magnitudes, summed
   function automatic uop_type sq_pair(logic [2:0] k);
      uop_type u;
      case (k)
         3'd0: u = mk(OP_T0L, OP_T0L, 2'd0, 1'b0, DST_NONE, 1'b0);
         3'd1: u = mk(OP_T0L, OP_T0H, 2'd1, 1'b0, DST_NONE, 1'b0);
         3'd2: u = mk(OP_T0H, OP_T0L, 2'd1, 1'b0, DST_NONE, 1'b0);
         3'd3: u = mk(OP_T0H, OP_T0H, 2'd2, 1'b0, DST_NONE, 1'b0);
         3'd4: u = mk(OP_T1L, OP_T1L, 2'd0, 1'b0, DST_NONE, 1'b0);
         3'd5: u = mk(OP_T1L, OP_T1H, 2'd1, 1'b0, DST_NONE, 1'b0);
         3'd6: u = mk(OP_T1H, OP_T1L, 2'd1, 1'b0, DST_NONE, 1'b0);
         default: u = mk(OP_T1H, OP_T1H, 2'd2, 1'b0, DST_NUM, 1'b0);
      endcase
      return u;
   endfunction

   function automatic uop_type prog_chordal(logic [4:0] idx);
      uop_type u;
      case (idx)
         5'd0:  u = mk(OP_SR, OP_AR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd1:  u = mk(OP_SI, OP_AI, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd2:  u = mk(OP_TR, OP_BR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd3:  u = mk(OP_TI, OP_BI, 2'd0, 1'b0, DST_T0, 1'b0);
         5'd4:  u = mk(OP_SI, OP_AR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd5:  u = mk(OP_SR, OP_AI, 2'd0, 1'b1, DST_NONE, 1'b0);
         5'd6:  u = mk(OP_TI, OP_BR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd7:  u = mk(OP_TR, OP_BI, 2'd0, 1'b1, DST_T1, 1'b0);
         5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
            u = sq_pair(3'(idx - 5'd8));
         5'd16: u = mk(OP_SR, OP_SR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd17: u = mk(OP_SI, OP_SI, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd18: u = mk(OP_TR, OP_TR, 2'd0, 1'b0, DST_NONE, 1'b0);
         default: u = mk(OP_TI, OP_TI, 2'd0, 1'b0, DST_DEN, 1'b1);
      endcase
      return u;
   endfunction

   function automatic uop_type prog_dist(logic [4:0] idx);
      uop_type u;
      case (idx)
         5'd0:  u = mk(OP_SR, OP_BR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd1:  u = mk(OP_SI, OP_BI, 2'd0, 1'b1, DST_NONE, 1'b0);
         5'd2:  u = mk(OP_AR, OP_TR, 2'd0, 1'b1, DST_NONE, 1'b0);
         5'd3:  u = mk(OP_AI, OP_TI, 2'd0, 1'b0, DST_T0, 1'b0);
         5'd4:  u = mk(OP_SR, OP_BI, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd5:  u = mk(OP_SI, OP_BR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd6:  u = mk(OP_AR, OP_TI, 2'd0, 1'b1, DST_NONE, 1'b0);
         5'd7:  u = mk(OP_AI, OP_TR, 2'd0, 1'b1, DST_T1, 1'b0);
         5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
            u = sq_pair(3'(idx - 5'd8));
         5'd16: u = mk(OP_TR, OP_TR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd17: u = mk(OP_TI, OP_TI, 2'd0, 1'b0, DST_T0, 1'b0);
         5'd18: u = mk(OP_BR, OP_BR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd19: u = mk(OP_BI, OP_BI, 2'd0, 1'b0, DST_T1, 1'b0);
         5'd20: u = mk(OP_ZERO, OP_ZERO, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd21: u = mk(OP_T0L, OP_T1L, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd22: u = mk(OP_T0L, OP_T1H, 2'd1, 1'b0, DST_NONE, 1'b0);
         5'd23: u = mk(OP_T0H, OP_T1L, 2'd1, 1'b0, DST_NONE, 1'b0);
         default: u = mk(OP_T0H, OP_T1H, 2'd2, 1'b0, DST_DEN, 1'b1);
      endcase
      return u;
   endfunction

   function automatic uop_type prog_bzero(logic [4:0] idx);
      uop_type u;
      case (idx)
         5'd0: u = mk(OP_SR, OP_SR, 2'd0, 1'b0, DST_NONE, 1'b0);
         5'd1: u = mk(OP_SI, OP_SI, 2'd0, 1'b0, DST_NUM, 1'b0);
         5'd2: u = mk(OP_TR, OP_TR, 2'd0, 1'b0, DST_NONE, 1'b0);
         default: u = mk(OP_TI, OP_TI, 2'd0, 1'b0, DST_DEN, 1'b1);
      endcase
      return u;
   endfunction

endpackage

FILE: rtl/core/eigen_pair_rank_by_target_top.sv
// channel | direction | transfer when          | payload
// req     | in        | start & !busy          | req_s_re req_s_im req_t_re req_t_im req_last_pair
// rsp     | out       | rsp_valid (one cycle)  | rsp_element_index rsp_rank rsp_last_rank
// csr     | in        | csr_valid & csr_ready  | csr_index csr_wdata
// A stored pair runs a distance, chordal or zero-B multiply program on the shared 33x33
// multiplier, then a divide and a square root.
// A zero divisor or a saturated key skips the divide and square root.
// Ranking compares each stored key with every stored key through one key memory read port.
// Reset is synchronous; it resets the state, pair count and CSR registers, not the key memory.
// Results cannot be stalled; csr_ready is always high.
`include "eigen_pair_rank_by_target_top_defines.svh"
module eigen_pair_rank_by_target_top #(
   parameter int MAX_PAIRS = eprt_pkg::MAX_PAIRS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [31:0]             req_s_re,
   input  logic signed [31:0]             req_s_im,
   input  logic signed [31:0]             req_t_re,
   input  logic signed [31:0]             req_t_im,
   input  logic                           req_last_pair,
   output logic                           rsp_valid,
   output logic [5:0]                     rsp_element_index,
   output logic [5:0]                     rsp_rank,
   output logic                           rsp_last_rank,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [eprt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import eprt_pkg::*;

   localparam int IDX_W = $clog2(MAX_PAIRS);
   localparam int CNT_W = $clog2(MAX_PAIRS + 1);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_CALC  = 11'b000_0000_0010,
      ST_DRAIN = 11'b000_0000_0100,
      ST_DIVI  = 11'b000_0000_1000,
      ST_DIV   = 11'b000_0001_0000,
      ST_SQRT  = 11'b000_0010_0000,
      ST_WRITE = 11'b000_0100_0000,
      ST_FETCH = 11'b000_1000_0000,
      ST_KEY   = 11'b001_0000_0000,
      ST_SCAN  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] cfg_a_re_ff, cfg_a_im_ff, cfg_b_re_ff, cfg_b_im_ff;
   logic        cfg_chordal_ff;

   logic signed [30:0] sr_ff, si_ff, tr_ff, ti_ff, ar_ff, ai_ff, br_ff, bi_ff;
   logic chord_ff, bzero_ff, last_ff;

   logic [4:0]          up_ff;
   uop_type             uop, ctl_ff;
   logic                pv_ff;
   logic signed [32:0]  opa, opb;
   logic signed [65:0]  prod_ff;
   logic [127:0]        acc_ff, addend, acc_nx;
   logic [63:0]         t0_ff, t1_ff, acc_mag;
   logic [127:0]        num_ff, den_ff;

   logic [127:0] rem_ff, rem0;
   logic [128:0] div_r2;
   logic [93:0]  q_ff;
   logic [6:0]   i_ff, num_idx;
   logic         div_bit, div_ge;

   logic [48:0] srem_ff;
   logic [46:0] root_ff, root_nx;
   logic [50:0] sq_r2, sq_trial;
   logic        sq_ge;
   logic [5:0]  sq_ff;

   logic             sh58, neg;
   logic [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0] pc_ff;

   logic [KEY_W-1:0] key_mem [MAX_PAIRS];
   logic [IDX_W-1:0] rd_addr;
   logic [KEY_W-1:0] rd_data_ff, keyi_ff;
   logic [IDX_W-1:0] ri_ff, jc_ff, cnt_ff;
   logic             lt, scan_done, out_last, accept;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign sh58 = !chord_ff;
   assign neg  = chord_ff || bzero_ff;

   always_comb begin
      if (chord_ff) begin
         uop = prog_chordal(up_ff);
      end else if (bzero_ff) begin
         uop = prog_bzero(up_ff);
      end else begin
         uop = prog_dist(up_ff);
      end
   end

   function automatic logic signed [32:0] pick(opnd_type o, logic signed [30:0] sr,
      logic signed [30:0] si, logic signed [30:0] tr, logic signed [30:0] ti,
      logic signed [30:0] ar, logic signed [30:0] ai, logic signed [30:0] br,
      logic signed [30:0] bi, logic [63:0] t0, logic [63:0] t1);
      logic signed [32:0] v;
      case (o)
         OP_SR:   v = 33'(sr);
         OP_SI:   v = 33'(si);
         OP_TR:   v = 33'(tr);
         OP_TI:   v = 33'(ti);
         OP_AR:   v = 33'(ar);
         OP_AI:   v = 33'(ai);
         OP_BR:   v = 33'(br);
         OP_BI:   v = 33'(bi);
         OP_T0L:  v = {1'b0, t0[31:0]};
         OP_T0H:  v = {1'b0, t0[63:32]};
         OP_T1L:  v = {1'b0, t1[31:0]};
         OP_T1H:  v = {1'b0, t1[63:32]};
         default: v = '0;
      endcase
      return v;
   endfunction

   assign opa = pick(uop.a, sr_ff, si_ff, tr_ff, ti_ff, ar_ff, ai_ff, br_ff, bi_ff,
                     t0_ff, t1_ff);
   assign opb = pick(uop.b, sr_ff, si_ff, tr_ff, ti_ff, ar_ff, ai_ff, br_ff, bi_ff,
                     t0_ff, t1_ff);

   always_comb begin
      case (ctl_ff.sh32)
         2'd1:    addend = 128'(prod_ff) << 32;
         2'd2:    addend = 128'(prod_ff) << 64;
         default: addend = 128'(prod_ff);
      endcase
      acc_nx  = ctl_ff.neg ? (acc_ff - addend) : (acc_ff + addend);
      acc_mag = acc_nx[63] ? (64'd0 - acc_nx[63:0]) : acc_nx[63:0];
   end

   assign rem0    = sh58 ? (num_ff >> 36) : (num_ff >> 94);
   assign num_idx = sh58 ? 7'(i_ff - 7'd58) : i_ff;
   assign div_bit = (!sh58 || (i_ff >= 7'd58)) ? num_ff[num_idx] : 1'b0;
   assign div_r2  = {rem_ff, div_bit};
   assign div_ge  = (div_r2 >= {1'b0, den_ff});

   assign sq_r2    = {srem_ff, q_ff[93:92]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_r2 >= sq_trial);
   assign root_nx  = {root_ff[45:0], sq_ge};

   assign lt = ($signed(rd_data_ff) < $signed(keyi_ff))
            || ((rd_data_ff == keyi_ff) && (jc_ff < ri_ff));
   assign scan_done = ((CNT_W'(jc_ff) + CNT_W'(1)) == pc_ff);
   assign out_last  = ((CNT_W'(ri_ff) + CNT_W'(1)) == pc_ff);

   always_comb begin
      case (state_ff)
         ST_FETCH: rd_addr = ri_ff;
         ST_KEY:   rd_addr = '0;
         default:  rd_addr = IDX_W'(jc_ff + IDX_W'(1));
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pc_ff < CNT_W'(MAX_PAIRS)) begin
                  state_in = ST_CALC;
               end else if (req_last_pair) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_CALC:  state_in = uop.last ? ST_DRAIN : ST_CALC;
         ST_DRAIN: state_in = ST_DIVI;
         ST_DIVI: begin
            if ((den_ff == '0) || (rem0 >= den_ff)) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:   state_in = (i_ff == 7'd0) ? ST_SQRT : ST_DIV;
         ST_SQRT:  state_in = (sq_ff == 6'd0) ? ST_WRITE : ST_SQRT;
         ST_WRITE: state_in = last_ff ? ST_FETCH : ST_IDLE;
         ST_FETCH: state_in = ST_KEY;
         ST_KEY:   state_in = ST_SCAN;
         ST_SCAN:  state_in = scan_done ? ST_OUT : ST_SCAN;
         ST_OUT:   state_in = out_last ? ST_IDLE : ST_FETCH;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cfg_a_re_ff    <= '0;
         cfg_a_im_ff    <= '0;
         cfg_b_re_ff    <= '0;
         cfg_b_im_ff    <= '0;
         cfg_chordal_ff <= 1'b1;
         pc_ff          <= '0;
         pv_ff          <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= (state_ff == ST_CALC);
         if (csr_valid) begin
            case (csr_index)
               CSR_A_RE:    cfg_a_re_ff    <= csr_wdata;
               CSR_A_IM:    cfg_a_im_ff    <= csr_wdata;
               CSR_B_RE:    cfg_b_re_ff    <= csr_wdata;
               CSR_B_IM:    cfg_b_im_ff    <= csr_wdata;
               CSR_CHORDAL: cfg_chordal_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == ST_WRITE) begin
            pc_ff <= CNT_W'(pc_ff + CNT_W'(1));
         end
         if ((state_ff == ST_OUT) && out_last) begin
            pc_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sr_ff    <= req_s_re[31:1];
         si_ff    <= req_s_im[31:1];
         tr_ff    <= req_t_re[31:1];
         ti_ff    <= req_t_im[31:1];
         ar_ff    <= cfg_a_re_ff[31:1];
         ai_ff    <= cfg_a_im_ff[31:1];
         br_ff    <= cfg_b_re_ff[31:1];
         bi_ff    <= cfg_b_im_ff[31:1];
         chord_ff <= cfg_chordal_ff;
         bzero_ff <= (cfg_b_re_ff[31:1] == '0) && (cfg_b_im_ff[31:1] == '0);
         last_ff  <= req_last_pair;
         up_ff    <= '0;
         acc_ff   <= '0;
         ri_ff    <= '0;
      end
      if (state_ff == ST_CALC) begin
         up_ff   <= 5'(up_ff + 5'd1);
         prod_ff <= opa * opb;
         ctl_ff  <= uop;
      end
      if (pv_ff) begin
         if (ctl_ff.dst == DST_NONE) begin
            acc_ff <= acc_nx;
         end else begin
            acc_ff <= '0;
         end
         case (ctl_ff.dst)
            DST_T0:  t0_ff  <= acc_mag;
            DST_T1:  t1_ff  <= acc_mag;
            DST_NUM: num_ff <= acc_nx;
            DST_DEN: den_ff <= acc_nx;
            default: ;
         endcase
      end
      case (state_ff)
         ST_DIVI: begin
            rem_ff <= rem0;
            i_ff   <= 7'd93;
            if (den_ff == '0) begin
               key_ff <= KEY_MAX;
            end else begin
               key_ff <= neg ? KEY_MAX_NEG : KEY_MAX;
            end
         end
         ST_DIV: begin
            rem_ff  <= div_ge ? 128'(div_r2 - {1'b0, den_ff}) : 128'(div_r2);
            q_ff    <= {q_ff[92:0], div_ge};
            i_ff    <= 7'(i_ff - 7'd1);
            srem_ff <= '0;
            root_ff <= '0;
            sq_ff   <= 6'd46;
         end
         ST_SQRT: begin
            srem_ff <= sq_ge ? 49'(sq_r2 - sq_trial) : 49'(sq_r2);
            root_ff <= root_nx;
            q_ff    <= {q_ff[91:0], 2'b00};
            sq_ff   <= 6'(sq_ff - 6'd1);
            key_ff  <= neg ? (KEY_W'(0) - {1'b0, root_nx}) : {1'b0, root_nx};
         end
         ST_WRITE: begin
            key_mem[pc_ff[IDX_W-1:0]] <= key_ff;
            ri_ff <= '0;
         end
         ST_KEY: begin
            keyi_ff <= rd_data_ff;
            jc_ff   <= '0;
            cnt_ff  <= '0;
         end
         ST_SCAN: begin
            cnt_ff <= IDX_W'(cnt_ff + IDX_W'(lt));
            jc_ff  <= IDX_W'(jc_ff + IDX_W'(1));
         end
         ST_OUT: begin
            ri_ff <= IDX_W'(ri_ff + IDX_W'(1));
         end
         default: ;
      endcase
      rd_data_ff <= key_mem[rd_addr];
   end

   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_element_index = 6'(ri_ff);
   assign rsp_rank          = 6'(cnt_ff);
   assign rsp_last_rank     = (state_ff == ST_OUT) && out_last;

   `EPRT_ASSERT(a_rsp_busy, clock, reset, rsp_valid |-> busy, "result outside a ranking pass")
   `EPRT_ASSERT(a_last_idle, clock, reset, rsp_last_rank |=> !busy, "no idle after final rank")
   `EPRT_ASSERT(a_pc_range, clock, reset, pc_ff <= CNT_W'(MAX_PAIRS), "pair count above limit")
   `EPRT_ASSERT(a_rem_ok, clock, reset, state_ff == ST_DIV |-> rem_ff < den_ff, "bad remainder")
   `EPRT_ASSERT_NR(a_reset_idle, clock, reset |=> !busy && !rsp_valid, "block active after reset")

endmodule
